// ----- hdl/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// Holds request modes, status codes, step constants and controller/datapath structs.
// No dependencies.
package bole_pkg;

  localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
  localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
  localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
  localparam logic [3:0] MODE_POP_BACK   = 4'd3;
  localparam logic [3:0] MODE_REMOVE     = 4'd4;
  localparam logic [3:0] MODE_FIND       = 4'd5;
  localparam logic [3:0] MODE_COUNT      = 4'd6;
  localparam logic [3:0] MODE_DUMP       = 4'd7;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_INVALID   = 3'd4;

  localparam logic signed [3:0] STEP_FRONT = -4'sd4;
  localparam logic signed [3:0] STEP_BACK  = 4'sd2;

  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_REMOVE,
    KIND_FIND,
    KIND_DUMP
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec_simple;
    logic emit_scan_empty;
    logic rd_cur;
    logic rd_next;
    logic idx_inc;
    logic wr_shift;
    logic emit_hit;
    logic emit_not_found;
    logic emit_dump;
    logic remove_done;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  cnt_zero;
    logic  match;
    logic  idx_last;
    logic  idx_last2;
  } dp_stat_t;

endpackage

// ----- hdl/bole_dpath.sv -----
// Datapath of the bounded ordered list engine: circular element store,
// front index, count, step, scan index and the registered result ports.
// Depends on bole_pkg.
module bole_dpath import bole_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] element_o,
  output logic [4:0]         position_o,
  output logic signed [6:0]  scaled_offset_o,
  output logic [4:0]         count_o,
  output logic               last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [31:0]        mem_q [DEPTH];
  logic [31:0]        rd_data_q;
  logic [3:0]         mode_q;
  logic [31:0]        value_q;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [3:0]  step_q, step_d;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [31:0]        mem_wdata;
  logic [AW-1:0]      idx_p1;
  logic [AW-1:0]      front_dec;
  logic               full;
  logic               emit;
  logic [2:0]         o_status;
  logic [31:0]        o_elem;
  logic [4:0]         o_pos;
  logic [6:0]         o_scaled;
  logic               o_last;
  logic [6:0]         idx7;
  logic signed [10:0] prod;
  kind_e              mode_kind;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                            input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, front} + {1'b0, k};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign idx_p1    = idx_q + AW'(1);
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
  assign full      = (count_q == FULL_C);
  assign idx7      = 7'(idx_q);
  assign prod      = $signed({4'b0000, idx7}) * $signed({{7{step_q[3]}}, step_q});

  always_comb begin
    case (mode_q)
      MODE_REMOVE: mode_kind = KIND_REMOVE;
      MODE_FIND:   mode_kind = KIND_FIND;
      MODE_DUMP:   mode_kind = KIND_DUMP;
      default:     mode_kind = KIND_SIMPLE;
    endcase
  end

  assign stat_o.kind      = mode_kind;
  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.match     = (rd_data_q == value_q);
  assign stat_o.idx_last  = ((XW'(idx_q) + XW'(1)) == XW'(count_q));
  assign stat_o.idx_last2 = ((XW'(idx_q) + XW'(2)) == XW'(count_q));

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    step_d    = step_q;
    idx_d     = idx_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = slot_of(front_q, idx_q);
    mem_wdata = rd_data_q;
    emit      = 1'b0;
    o_status  = STAT_OK;
    o_elem    = '0;
    o_pos     = '0;
    o_scaled  = '0;
    o_last    = 1'b1;

    if (cmd_i.capture) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1;
    end

    if (cmd_i.exec_simple) begin
      emit = 1'b1;
      case (mode_q)
        MODE_PUSH_FRONT: begin
          step_d = STEP_FRONT;
          if (full) begin
            o_status = STAT_FULL;
          end else begin
            front_d   = front_dec;
            mem_we    = 1'b1;
            mem_addr  = front_dec;
            mem_wdata = value_q;
            count_d   = count_q + CW'(1);
          end
        end
        MODE_PUSH_BACK: begin
          step_d = STEP_BACK;
          if (full) begin
            o_status = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_addr  = slot_of(front_q, AW'(count_q));
            mem_wdata = value_q;
            count_d   = count_q + CW'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (count_q == '0) begin
            o_status = STAT_EMPTY;
          end else begin
            front_d = slot_of(front_q, AW'(1));
            count_d = count_q - CW'(1);
          end
        end
        MODE_POP_BACK: begin
          if (count_q == '0) begin
            o_status = STAT_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        MODE_COUNT: begin
          o_status = STAT_OK;
        end
        default: begin
          o_status = STAT_INVALID;
        end
      endcase
    end

    if (cmd_i.emit_scan_empty) begin
      emit     = 1'b1;
      o_status = (mode_q == MODE_DUMP) ? STAT_EMPTY : STAT_NOT_FOUND;
    end

    if (cmd_i.rd_cur) begin
      mem_re   = 1'b1;
      mem_addr = slot_of(front_q, idx_q);
    end

    if (cmd_i.rd_next) begin
      mem_re   = 1'b1;
      mem_addr = slot_of(front_q, idx_p1);
    end

    if (cmd_i.wr_shift) begin
      mem_we    = 1'b1;
      mem_addr  = slot_of(front_q, idx_q);
      mem_wdata = rd_data_q;
    end

    if (cmd_i.emit_hit) begin
      emit     = 1'b1;
      // The position is one wider than the index so a hit in the last slot
      // of a full list reads as DEPTH.
      o_pos    = 5'({1'b0, idx_q} + (AW + 1)'(1));
      o_scaled = prod[6:0];
    end

    if (cmd_i.emit_not_found) begin
      emit     = 1'b1;
      o_status = STAT_NOT_FOUND;
    end

    if (cmd_i.emit_dump) begin
      emit   = 1'b1;
      o_elem = rd_data_q;
      o_last = stat_o.idx_last;
    end

    if (cmd_i.remove_done) begin
      emit    = 1'b1;
      count_d = count_q - CW'(1);
    end
  end

  // Single-port element store with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      step_q   <= '0;
      strobe_o <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      step_q   <= step_d;
      strobe_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (emit) begin
      status_o        <= o_status;
      element_o       <= o_elem;
      position_o      <= o_pos;
      scaled_offset_o <= o_scaled;
      count_o         <= 5'(count_d);
      last_o          <= o_last;
    end
  end

endmodule

// ----- hdl/bole_ctrl.sv -----
// Controller of the bounded ordered list engine: sequences decode, scan,
// shift and read-out steps and issues commands to the datapath.
// Depends on bole_pkg.
module bole_ctrl import bole_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SHWR   = 3'd3;
  localparam logic [2:0] S_SHRD   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.kind == KIND_SIMPLE) begin
          cmd_o.exec_simple = 1'b1;
          state_d           = S_IDLE;
        end else if (stat_i.cnt_zero) begin
          cmd_o.emit_scan_empty = 1'b1;
          state_d               = S_IDLE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat_i.kind)
          KIND_DUMP: begin
            cmd_o.emit_dump = 1'b1;
            if (stat_i.idx_last) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.rd_next = 1'b1;
              cmd_o.idx_inc = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (stat_i.match && stat_i.idx_last) begin
              cmd_o.remove_done = 1'b1;
              state_d           = S_IDLE;
            end else if (stat_i.match) begin
              cmd_o.rd_next = 1'b1;
              state_d       = S_SHWR;
            end else if (stat_i.idx_last) begin
              cmd_o.emit_not_found = 1'b1;
              state_d              = S_IDLE;
            end else begin
              cmd_o.rd_next = 1'b1;
              cmd_o.idx_inc = 1'b1;
            end
          end
          default: begin
            if (stat_i.match) begin
              cmd_o.emit_hit = 1'b1;
              state_d        = S_IDLE;
            end else if (stat_i.idx_last) begin
              cmd_o.emit_not_found = 1'b1;
              state_d              = S_IDLE;
            end else begin
              cmd_o.rd_next = 1'b1;
              cmd_o.idx_inc = 1'b1;
            end
          end
        endcase
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        if (stat_i.idx_last2) begin
          cmd_o.remove_done = 1'b1;
          state_d           = S_IDLE;
        end else begin
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        cmd_o.rd_next = 1'b1;
        state_d       = S_SHWR;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine.
// Joins the controller (bole_ctrl) and the datapath (bole_dpath); uses bole_pkg.
//
// Usage: a request (mode_i, value_i) is taken at a rising edge where start is
// high and busy is low. Each result appears on the result ports for exactly
// one cycle with strobe_o high; the receiver cannot stall, so it must take it.
// Simple modes (push, pop, count, invalid) and requests on an empty list
// are handled in the decode state; their single result is then registered
// onto the result ports, and busy drops in the same cycle the result shows.
// Find and remove read the single-port store one entry per cycle, from the
// front up to a hit or the last entry. A remove that hits at position p then
// shifts every later element down one slot, with a read and then a write for
// each; the one memory port keeps these from overlapping, and a hit at the
// front is the worst case. A dump gives one result per cycle, element by
// element from the front, with last_o on the final one.
// A new request can be taken in the same cycle the final result is shown.
// Reset (rst_ni low, asynchronous) empties the list, clears the front index and
// step, and returns the controller to idle. The store itself is not cleared;
// only slots holding live elements are ever read.
module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] element_o,
  output logic [4:0]         position_o,
  output logic signed [6:0]  scaled_offset_o,
  output logic [4:0]         count_o,
  output logic               last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller only sequences; all list state lives in the datapath.
  bole_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bole_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .strobe_o        (strobe_o),
    .status_o        (status_o),
    .element_o       (element_o),
    .position_o      (position_o),
    .scaled_offset_o (scaled_offset_o),
    .count_o         (count_o),
    .last_o          (last_o)
  );

endmodule

// ----- test/list_result_checker.sv -----
// Result checker for the bounded ordered list engine testbench.
// Predicts every result from the requests it sees and compares them with the block's results.
// Depends on bole_pkg for the mode and status codes.
module list_result_checker import bole_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic               strobe_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] element_i,
  input  logic [4:0]         position_i,
  input  logic signed [6:0]  scaled_offset_i,
  input  logic [4:0]         count_i,
  input  logic               last_i,
  output int                 mismatches_o,
  output int                 outstanding_o,
  output int                 results_seen_o,
  output int                 peak_fill_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [4:0]         position;
    logic signed [6:0]  scaled_offset;
    logic [4:0]         count;
    logic               last;
  } list_result_t;

  // Model of the list contents, front first, and of the find step.
  logic signed [31:0] held_values[$];
  int                 find_step;
  list_result_t       awaited_results[$];

  assign outstanding_o = awaited_results.size();

  function automatic void queue_result(input logic [2:0] status,
                                       input logic signed [31:0] element,
                                       input logic [4:0] position,
                                       input logic signed [6:0] scaled_offset,
                                       input logic last);
    list_result_t res;
    res.status        = status;
    res.element       = element;
    res.position      = position;
    res.scaled_offset = scaled_offset;
    res.count         = 5'(held_values.size());
    res.last          = last;
    awaited_results.push_back(res);
  endfunction

  // Applies one request to the list model and queues the results it causes.
  function automatic void apply_list_request(input logic [3:0] mode,
                                             input logic signed [31:0] value);
    int hit;
    hit = -1;
    foreach (held_values[i]) begin
      if (hit < 0 && held_values[i] == value) hit = i;
    end
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        // The step follows the insert side even when the insert is refused.
        find_step = (mode == MODE_PUSH_FRONT) ? int'(STEP_FRONT) : int'(STEP_BACK);
        if (held_values.size() >= DEPTH) begin
          queue_result(STAT_FULL, '0, '0, '0, 1'b1);
        end else begin
          if (mode == MODE_PUSH_FRONT) held_values.push_front(value);
          else held_values.push_back(value);
          queue_result(STAT_OK, '0, '0, '0, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (held_values.size() == 0) begin
          queue_result(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          if (mode == MODE_POP_FRONT) void'(held_values.pop_front());
          else void'(held_values.pop_back());
          queue_result(STAT_OK, '0, '0, '0, 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (hit < 0) begin
          queue_result(STAT_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          held_values.delete(hit);
          queue_result(STAT_OK, '0, '0, '0, 1'b1);
        end
      end
      MODE_FIND: begin
        if (hit < 0) queue_result(STAT_NOT_FOUND, '0, '0, '0, 1'b1);
        else queue_result(STAT_OK, '0, 5'(hit + 1), 7'(hit * find_step), 1'b1);
      end
      MODE_COUNT: begin
        queue_result(STAT_OK, '0, '0, '0, 1'b1);
      end
      MODE_DUMP: begin
        if (held_values.size() == 0) begin
          queue_result(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          foreach (held_values[i]) begin
            queue_result(STAT_OK, held_values[i], '0, '0, i == held_values.size() - 1);
          end
        end
      end
      default: begin
        queue_result(STAT_INVALID, '0, '0, '0, 1'b1);
      end
    endcase
    if (held_values.size() > peak_fill_o) peak_fill_o = held_values.size();
  endfunction

  function automatic void compare_result(input list_result_t want, input list_result_t got);
    if (got.status !== want.status || got.element !== want.element ||
        got.position !== want.position || got.scaled_offset !== want.scaled_offset ||
        got.count !== want.count || got.last !== want.last) begin
      mismatches_o++;
      if (mismatches_o <= REPORT_LIMIT) begin
        $display("[%0t] result mismatch: expected status %0d element %0d pos %0d off %0d",
                 $realtime, want.status, want.element, want.position, want.scaled_offset);
        $display("    count %0d last %0b; got status %0d element %0d pos %0d off %0d",
                 want.count, want.last, got.status, got.element, got.position,
                 got.scaled_offset);
        $display("    count %0d last %0b", got.count, got.last);
      end
    end
  endfunction

  initial begin
    mismatches_o   = 0;
    results_seen_o = 0;
    peak_fill_o    = 0;
    find_step      = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    if (!rst_ni) begin
      held_values.delete();
      awaited_results.delete();
      find_step = 0;
    end else begin
      // Results shown at this edge belong to earlier requests, so they are
      // retired before a request taken at the same edge is predicted.
      if (strobe_i) begin
        results_seen_o++;
        got = '{status_i, element_i, position_i, scaled_offset_i, count_i, last_i};
        if (awaited_results.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= REPORT_LIMIT) begin
            $display("[%0t] result with nothing expected: status %0d element %0d",
                     $realtime, status_i, element_i);
          end
        end else begin
          compare_result(awaited_results.pop_front(), got);
        end
      end
      if (start_i && !busy_i) apply_list_request(mode_i, value_i);
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the bounded ordered list engine testbench.
// Drives directed and random list requests into the block and gives the verdict.
// Depends on bole_pkg, bounded_ordered_list_engine and list_result_checker.
module tb_top import bole_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH              = 16;
  localparam int         WATCHDOG_LIMIT     = 2000;
  localparam int         TAIL_CYCLES        = 40;
  localparam int         ITEMS_PER_PHASE    = 32;
  localparam logic [3:0] FIRST_INVALID_MODE = 4'd8;
  localparam logic [3:0] LAST_INVALID_MODE  = 4'd15;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               req_start = 1'b0;
  logic               req_busy;
  logic [3:0]         req_mode  = MODE_COUNT;
  logic signed [31:0] req_value = '0;
  logic               rsp_strobe;
  logic [2:0]         rsp_status;
  logic signed [31:0] rsp_element;
  logic [4:0]         rsp_position;
  logic signed [6:0]  rsp_scaled_offset;
  logic [4:0]         rsp_count;
  logic               rsp_last;

  int mismatches;
  int outstanding;
  int results_seen;
  int peak_fill;
  int requests_sent = 0;
  bit gaps_enabled  = 1'b1;

  always #5 clk_i = ~clk_i;

  bounded_ordered_list_engine #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (req_start),
    .busy           (req_busy),
    .mode_i         (req_mode),
    .value_i        (req_value),
    .strobe_o       (rsp_strobe),
    .status_o       (rsp_status),
    .element_o      (rsp_element),
    .position_o     (rsp_position),
    .scaled_offset_o(rsp_scaled_offset),
    .count_o        (rsp_count),
    .last_o         (rsp_last)
  );

  list_result_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (req_start),
    .busy_i         (req_busy),
    .mode_i         (req_mode),
    .value_i        (req_value),
    .strobe_i       (rsp_strobe),
    .status_i       (rsp_status),
    .element_i      (rsp_element),
    .position_i     (rsp_position),
    .scaled_offset_i(rsp_scaled_offset),
    .count_i        (rsp_count),
    .last_i         (rsp_last),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen),
    .peak_fill_o    (peak_fill)
  );

  // The watchdog restarts whenever a request or a result is taken. A stretch
  // longer than the limit means the block has hung or dropped a result.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_start && !req_busy) || rsp_strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no request or result taken for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Presents one request and holds it until the block takes it. The task
  // returns in the time step of the accepting edge, so the next request can
  // follow back to back with a single assignment to the start line. An idle
  // gap lowers start first and raises it again at a later edge.
  task automatic issue_request(input logic [3:0] mode, input logic signed [31:0] value);
    if (gaps_enabled && $urandom_range(0, 99) < 9) begin
      req_start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_start <= 1'b1;
    req_mode  <= mode;
    req_value <= value;
    do @(posedge clk_i); while (req_busy);
    requests_sent++;
  endtask

  // Holds the sender off until every predicted result has come back and the
  // block is idle again.
  task automatic drain_results();
    req_start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || req_busy);
  endtask

  // Values mostly come from a small pool with repeats and the extremes, so
  // that finds and removes hit often and first-occurrence matters; the rest
  // are fully random words.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool[6];
    pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh5, 32'sh3039};
    if ($urandom_range(0, 99) < 60) return pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Pushes take push_share percent of the requests; the rest is spread over
  // the other modes, with a few invalid codes.
  function automatic logic [3:0] pick_mode(input int push_share);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_share) return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    roll = $urandom_range(0, 99);
    if (roll < 15) return MODE_POP_FRONT;
    if (roll < 30) return MODE_POP_BACK;
    if (roll < 50) return MODE_REMOVE;
    if (roll < 75) return MODE_FIND;
    if (roll < 83) return MODE_COUNT;
    if (roll < 93) return MODE_DUMP;
    return 4'($urandom_range(FIRST_INVALID_MODE, LAST_INVALID_MODE));
  endfunction

  initial begin
    int push_share;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: every mode but the pushes on the empty list, both invalid extremes,
    // then a short list with the extreme values and duplicates so that find
    // and remove must pick the first occurrence under both step values.
    issue_request(MODE_COUNT, '0);
    issue_request(MODE_POP_FRONT, '0);
    issue_request(MODE_POP_BACK, '0);
    issue_request(MODE_REMOVE, 32'sh5);
    issue_request(MODE_FIND, 32'sh5);
    issue_request(MODE_DUMP, '0);
    issue_request(FIRST_INVALID_MODE, $urandom);
    issue_request(LAST_INVALID_MODE, -32'sh1);
    issue_request(MODE_PUSH_FRONT, 32'sh8000_0000);
    issue_request(MODE_PUSH_FRONT, 32'sh5);
    issue_request(MODE_PUSH_BACK, 32'sh7fff_ffff);
    issue_request(MODE_PUSH_BACK, -32'sh1);
    issue_request(MODE_PUSH_FRONT, 32'sh0);
    issue_request(MODE_FIND, -32'sh1);
    issue_request(MODE_PUSH_BACK, 32'sh5);
    issue_request(MODE_FIND, 32'sh5);
    issue_request(MODE_REMOVE, 32'sh5);
    issue_request(MODE_FIND, 32'sh5);
    issue_request(MODE_FIND, 32'sh8000_0000);
    issue_request(MODE_DUMP, '0);
    issue_request(MODE_POP_FRONT, '0);
    issue_request(MODE_POP_BACK, '0);
    issue_request(MODE_REMOVE, 32'sh3039);
    issue_request(MODE_COUNT, '0);

    // The sender waits here for every outstanding result at least once.
    drain_results();

    // Random requests in three phases: one that grows the list until it is
    // full and refuses inserts, one balanced phase run without idle gaps,
    // and one that drains the list down to empty pops and dumps.
    for (int phase = 0; phase < 3; phase++) begin
      push_share   = (phase == 0) ? 75 : (phase == 1) ? 45 : 15;
      gaps_enabled = (phase != 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        issue_request(pick_mode(push_share), pick_value());
      end
      drain_results();
    end

    req_start <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results; the list held up to %0d of %0d.",
             requests_sent, results_seen, peak_fill, DEPTH);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
